/* sv/jrle_pkg.sv */
// ============================================================================
// jrle_pkg: shared definitions for the JPEG coefficient symbolizer
// Symbol kinds, block constants and the command and status bundles that
// join the controller to the datapath.
// ============================================================================
package jrle_pkg;

    // Number of color components that keep a DC predictor of their own.
    localparam int NUM_COMPONENTS = 3;
    localparam int COMP_W = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

    localparam int COEF_W  = 11;
    localparam int BLOCK_SIZE = 64;
    localparam int POS_W   = $clog2(BLOCK_SIZE);
    localparam int ZRL_LENGTH = 16;
    localparam logic [7:0] ZRL_SYMBOL = 8'hF0;

    // Symbol kinds on the result channel.
    localparam logic [1:0] KIND_DC  = 2'd0;
    localparam logic [1:0] KIND_AC  = 2'd1;
    localparam logic [1:0] KIND_ZRL = 2'd2;
    localparam logic [1:0] KIND_EOB = 2'd3;

    // Source of the symbol loaded into the output register.
    typedef enum logic [1:0] {
        OSEL_ITEM = 2'd0,  // symbol of the item on the input ports
        OSEL_ZRL  = 2'd1,  // one run of sixteen zeros
        OSEL_HELD = 2'd2   // run/size symbol of the held coefficient
    } osel_t;

    typedef struct packed {
        logic  accept;  // an input transfer happens this cycle
        logic  load;    // load the output register
        osel_t sel;     // what the output register loads
        logic  take;    // the output transfer happens this cycle
    } jrle_cmd_t;

    typedef struct packed {
        logic in_emit;    // the item on the input ports causes a result
        logic in_zrl;     // that result begins with zero-run symbols
        logic zcnt_zero;  // no more zero-run symbols are pending
        logic out_valid;  // the output register holds a symbol
    } jrle_status_t;

endpackage

/* sv/jrle_ctrl.sv */
// ============================================================================
// jrle_ctrl: sequencing controller
// Decides when an input item is taken and when the output register loads,
// and steps through the zero-run symbols that precede a late nonzero value.
// ============================================================================
module jrle_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  m_ready,
    input  jrle_pkg::jrle_status_t status,
    output jrle_pkg::jrle_cmd_t   cmd
);
    import jrle_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_ZRL  = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_free;
    logic accept;

    assign out_free = !status.out_valid || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd.accept = accept;
        cmd.take   = status.out_valid && m_ready;
        cmd.load   = 1'b0;
        cmd.sel    = OSEL_ITEM;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.sel  = status.in_zrl ? OSEL_ZRL : OSEL_ITEM;
                cmd.load = accept && status.in_emit;
                if (accept && status.in_emit && status.in_zrl) begin
                    state_next = ST_ZRL;
                end
            end
            ST_ZRL: begin
                cmd.sel  = status.zcnt_zero ? OSEL_HELD : OSEL_ZRL;
                cmd.load = out_free;
                if (out_free && status.zcnt_zero) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/jrle_datapath.sv */
// ============================================================================
// jrle_datapath: predictor, run counter and symbol formatter
// Holds the DC predictors, block position and zero-run count, forms size
// categories and amplitude bits, and owns the output register.
// ============================================================================
module jrle_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic signed [10:0]     s_coefficient,
    input  logic [1:0]             s_component,
    input  jrle_pkg::jrle_cmd_t    cmd,
    output jrle_pkg::jrle_status_t status,
    output logic [1:0]             m_symbol_kind,
    output logic [7:0]             m_symbol_value,
    output logic [10:0]            m_extra_bits,
    output logic [3:0]             m_extra_length,
    output logic                   m_last_of_run
);
    import jrle_pkg::*;

    // Number of significant magnitude bits of a 12-bit signed value.
    function automatic logic [3:0] size_of(input logic signed [11:0] v);
        logic [11:0] mag;
        logic [3:0]  s;
        mag = v[11] ? 12'(-v) : v;
        s = 4'd0;
        for (int i = 0; i < 12; i++) begin
            if (mag[i]) begin
                s = 4'(i + 1);
            end
        end
        return s;
    endfunction

    // A negative value goes out as its value minus one, kept to size bits.
    function automatic logic [10:0] amp_of(input logic signed [11:0] v,
                                           input logic [3:0] s);
        logic [11:0] t;
        logic [11:0] mask;
        t = v[11] ? 12'(v - 12'sd1) : v;
        mask = ~(12'hFFF << s);
        return 11'(t & mask);
    endfunction

    logic [COEF_W-1:0]      prev_dc_reg [NUM_COMPONENTS];
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       zrun_reg;
    logic [1:0]             zcnt_reg;
    logic signed [10:0]     held_reg;
    logic                   out_valid_reg;
    logic [1:0]             kind_reg;
    logic [7:0]             value_reg;
    logic [10:0]            bits_reg;
    logic [3:0]             len_reg;
    logic                   last_reg;

    logic [COMP_W-1:0]      comp_idx;
    logic                   is_dc;
    logic                   is_last;
    logic                   coef_zero;
    logic signed [11:0]     diff;
    logic signed [11:0]     val;
    logic [3:0]             size;
    logic [10:0]            amp;
    logic [1:0]             kind_next;
    logic [7:0]             value_next;
    logic [10:0]            bits_next;
    logic [3:0]             len_next;
    logic                   last_next;

    assign comp_idx  = (int'(s_component) < NUM_COMPONENTS) ? s_component[COMP_W-1:0] : '0;
    assign is_dc     = (pos_reg == '0);
    assign is_last   = (pos_reg == POS_W'(BLOCK_SIZE - 1));
    assign coef_zero = (s_coefficient == '0);
    assign diff      = 12'({s_coefficient[10], s_coefficient})
                     - 12'({prev_dc_reg[comp_idx][10], prev_dc_reg[comp_idx]});

    // One size unit serves the DC difference, the AC value and the held value.
    assign val  = (cmd.sel == OSEL_HELD) ? 12'({held_reg[10], held_reg})
                : (is_dc ? diff : 12'({s_coefficient[10], s_coefficient}));
    assign size = size_of(val);
    assign amp  = amp_of(val, size);

    assign status.in_emit   = is_dc || !coef_zero || is_last;
    assign status.in_zrl    = !is_dc && !coef_zero && (zrun_reg >= POS_W'(ZRL_LENGTH));
    assign status.zcnt_zero = (zcnt_reg == 2'd0);
    assign status.out_valid = out_valid_reg;

    always_comb begin
        kind_next  = KIND_AC;
        value_next = {zrun_reg[3:0], size};
        bits_next  = amp;
        len_next   = size;
        last_next  = 1'b1;
        case (cmd.sel)
            OSEL_ZRL: begin
                kind_next  = KIND_ZRL;
                value_next = ZRL_SYMBOL;
                bits_next  = '0;
                len_next   = '0;
                last_next  = 1'b0;
            end
            OSEL_ITEM: begin
                if (is_dc) begin
                    kind_next  = KIND_DC;
                    value_next = 8'(size);
                end else if (coef_zero) begin
                    kind_next  = KIND_EOB;
                    value_next = '0;
                    bits_next  = '0;
                    len_next   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_COMPONENTS; i++) begin
                prev_dc_reg[i] <= '0;
            end
            pos_reg       <= '0;
            zrun_reg      <= '0;
            zcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.accept) begin
                pos_reg <= is_last ? '0 : POS_W'(pos_reg + 1'b1);
                if (is_dc) begin
                    prev_dc_reg[comp_idx] <= s_coefficient;
                    zrun_reg <= '0;
                end else if (coef_zero) begin
                    zrun_reg <= is_last ? '0 : POS_W'(zrun_reg + 1'b1);
                end else if (!status.in_zrl) begin
                    zrun_reg <= '0;
                end
                if (status.in_zrl) begin
                    zcnt_reg <= 2'(zrun_reg[5:4] - 2'd1);
                end
            end else if (cmd.load && cmd.sel == OSEL_ZRL) begin
                zcnt_reg <= 2'(zcnt_reg - 2'd1);
            end else if (cmd.load && cmd.sel == OSEL_HELD) begin
                zrun_reg <= '0;
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (cmd.take) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            held_reg <= s_coefficient;
        end
        if (cmd.load) begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            bits_reg  <= bits_next;
            len_reg   <= len_next;
            last_reg  <= last_next;
        end
    end

    assign m_symbol_kind  = kind_reg;
    assign m_symbol_value = value_reg;
    assign m_extra_bits   = bits_reg;
    assign m_extra_length = len_reg;
    assign m_last_of_run  = last_reg;

endmodule

/* sv/jpeg_coefficient_rle_symbolizer.sv */
// ============================================================================
// jpeg_coefficient_rle_symbolizer: JPEG DC DPCM and AC run-length symbols
// Turns quantized zigzag coefficients, 64 per block, into DC category,
// AC run/size, zero-run and end-of-block symbols with amplitude bits.
// ============================================================================
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    coefficient (11 b signed), component
//  m_       out        m_valid/m_ready    kind, value, extra bits/length, last
//
// A new coefficient is taken every cycle as long as the output register is
// empty or is being drained in the same cycle. A nonzero AC value after N
// full groups of sixteen zeros (N at most 3) goes out as N zero-run symbols
// and then its run/size symbol, one by one through the single output
// register; no new coefficient is taken until the last of them loads. Zero
// AC values inside a block cause no transfer on the output side.
// Reset clears the DC predictors, block position and zero-run count at once;
// no clearing pass is needed. A stall on m_ready holds the current symbol
// and stops input transfers until the output register frees up.
//
module jpeg_coefficient_rle_symbolizer (
    input  logic               aclk,
    input  logic               aresetn,
    // Coefficient input.
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [10:0] s_coefficient,
    input  logic [1:0]         s_component,
    // Symbol output.
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_symbol_kind,
    output logic [7:0]         m_symbol_value,
    output logic [10:0]        m_extra_bits,
    output logic [3:0]         m_extra_length,
    output logic               m_last_of_run
);
    import jrle_pkg::*;

    jrle_cmd_t    cmd;
    jrle_status_t status;

    // The controller owns the handshake decisions; the datapath only follows
    // its commands and reports what the current input item needs.
    jrle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    jrle_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_coefficient  (s_coefficient),
        .s_component    (s_component),
        .cmd            (cmd),
        .status         (status),
        .m_symbol_kind  (m_symbol_kind),
        .m_symbol_value (m_symbol_value),
        .m_extra_bits   (m_extra_bits),
        .m_extra_length (m_extra_length),
        .m_last_of_run  (m_last_of_run)
    );

    // The output register's valid flag is the channel's valid.
    assign m_valid = status.out_valid;

endmodule

/* sv/jrle_checker.sv */
// ============================================================================
// jrle_checker: port-level checks for the coefficient symbolizer
// Watches the result channel for stalled symbols that change and for
// symbol fields that disagree with their kind.
// ============================================================================
module jrle_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_symbol_kind,
    input logic [7:0]  m_symbol_value,
    input logic [10:0] m_extra_bits,
    input logic [3:0]  m_extra_length,
    input logic        m_last_of_run
);
    import jrle_pkg::*;

    // A stalled symbol stays put until its transfer.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_symbol_kind)
            && $stable(m_symbol_value) && $stable(m_extra_bits)
            && $stable(m_extra_length) && $stable(m_last_of_run))
        else $error("symbol changed while stalled");

    // A zero-run symbol never ends an item and carries no amplitude.
    a_zrl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_symbol_kind == KIND_ZRL |->
            m_symbol_value == ZRL_SYMBOL && m_extra_length == 4'd0 && !m_last_of_run)
        else $error("malformed zero-run symbol");

    // End of block closes its item and carries nothing else.
    a_eob: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_symbol_kind == KIND_EOB |->
            m_symbol_value == 8'd0 && m_extra_length == 4'd0 && m_last_of_run)
        else $error("malformed end-of-block symbol");

    // DC and AC symbols carry their size as the amplitude length.
    a_size: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_symbol_kind == KIND_DC || m_symbol_kind == KIND_AC) |->
            m_symbol_value[3:0] == m_extra_length && m_last_of_run
            && (m_extra_bits >> m_extra_length) == 11'd0)
        else $error("size and amplitude bits disagree");

endmodule

bind jpeg_coefficient_rle_symbolizer jrle_checker u_jrle_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_symbol_kind  (m_symbol_kind),
    .m_symbol_value (m_symbol_value),
    .m_extra_bits   (m_extra_bits),
    .m_extra_length (m_extra_length),
    .m_last_of_run  (m_last_of_run)
);
